// ===== rtl/ppte_pkg.sv =====
package ppte_pkg;

    localparam int AXES = 3;

    // Last derivative order of a motion sample run (position .. jerk)
    localparam logic [2:0] SAMPLE_LAST_ORDER = 3'd3;

    localparam logic [1:0] CFG_START_TIME     = 2'd0;
    localparam logic [1:0] CFG_TRAJ_LEN       = 2'd1;
    localparam logic [1:0] CFG_SEGMENT_COUNT  = 2'd2;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_WR_DUR  = 2'd0,
        OP_WR_COEF = 2'd1,
        OP_EVAL    = 2'd2,
        OP_SAMPLE  = 2'd3
    } t_op;

    typedef struct packed {
        logic idle;
        logic load;
        logic clr_step;
        logic s_adv;
        logic s_fin;
        logic ax_zero;
        logic ax_start;
        logic ax_store;
        logic ax_next;
        logic rw;
        logic scl;
        logic mabs;
        logic mlo;
        logic mhi;
        logic mrnd;
        logic add;
        logic k_dec;
        logic push;
        logic ord_next;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic n_zero;
        logic srch_more;
        logic zero_axis;
        logic scl_done;
        logic k_first;
        logic k_done;
        logic ax_last;
        logic ord_last;
    } t_stat;

endpackage

// ===== rtl/ppte_ctrl.sv =====
module ppte_ctrl
    import ppte_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_op   i_op,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [14:0] {
        S_CLEAR = 15'h0001,
        S_IDLE  = 15'h0002,
        S_SRD   = 15'h0004,
        S_SCMP  = 15'h0008,
        S_AX    = 15'h0010,
        S_RD    = 15'h0020,
        S_RW    = 15'h0040,
        S_SCL   = 15'h0080,
        S_MABS  = 15'h0100,
        S_MLO   = 15'h0200,
        S_MHI   = 15'h0400,
        S_MRND  = 15'h0800,
        S_ADD   = 15'h1000,
        S_STO   = 15'h2000,
        S_PUSH  = 15'h4000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                o_cmd.load = i_accept;
                if (i_accept && (i_op == OP_EVAL || i_op == OP_SAMPLE)) n_state = S_SRD;
            end
            S_SRD: begin
                // wait for the duration read
                n_state = i_stat.n_zero ? S_AX : S_SCMP;
            end
            S_SCMP: begin
                if (i_stat.srch_more) begin
                    o_cmd.s_adv = 1'b1;
                    n_state     = S_SRD;
                end else begin
                    o_cmd.s_fin = 1'b1;
                    n_state     = S_AX;
                end
            end
            S_AX: begin
                if (i_stat.zero_axis) begin
                    o_cmd.ax_zero = 1'b1;
                    if (i_stat.ax_last) begin
                        n_state = S_PUSH;
                    end else begin
                        o_cmd.ax_next = 1'b1;
                    end
                end else begin
                    o_cmd.ax_start = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: n_state = S_RW;
            S_RW: begin
                o_cmd.rw = 1'b1;
                n_state  = S_SCL;
            end
            S_SCL: begin
                if (i_stat.scl_done) begin
                    n_state = i_stat.k_first ? S_ADD : S_MABS;
                end else begin
                    o_cmd.scl = 1'b1;
                end
            end
            S_MABS: begin
                o_cmd.mabs = 1'b1;
                n_state    = S_MLO;
            end
            S_MLO: begin
                o_cmd.mlo = 1'b1;
                n_state   = S_MHI;
            end
            S_MHI: begin
                o_cmd.mhi = 1'b1;
                n_state   = S_MRND;
            end
            S_MRND: begin
                o_cmd.mrnd = 1'b1;
                n_state    = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (i_stat.k_done) begin
                    n_state = S_STO;
                end else begin
                    o_cmd.k_dec = 1'b1;
                    n_state     = S_RD;
                end
            end
            S_STO: begin
                o_cmd.ax_store = 1'b1;
                if (i_stat.ax_last) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.ax_next = 1'b1;
                    n_state       = S_AX;
                end
            end
            S_PUSH: begin
                // hold until the output register frees up
                if (i_out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_stat.ord_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.ord_next = 1'b1;
                        n_state        = S_AX;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

// ===== rtl/ppte_dp.sv =====
module ppte_dp
    import ppte_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int NUM_COEFFS   = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  t_op          i_op,
    input  logic [3:0]   i_segment_index,
    input  logic [1:0]   i_axis,
    input  logic [2:0]   i_coeff_index,
    input  logic [63:0]  i_coeff_value,
    input  logic [31:0]  i_duration_value,
    input  logic [31:0]  i_query_time,
    input  logic [2:0]   i_deriv_order,
    input  logic [31:0]  i_start_time,
    input  logic [31:0]  i_traj_len,
    input  logic [4:0]   i_segment_count,
    output logic [2:0]   o_order,
    output logic [63:0]  o_x_value,
    output logic [63:0]  o_y_value,
    output logic [63:0]  o_z_value
);

    localparam int SW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int ROWLEN = AXES * NUM_COEFFS;
    localparam int DEPTH  = MAX_SEGMENTS * ROWLEN;
    localparam int AW     = $clog2(DEPTH);
    localparam int KW     = $clog2(NUM_COEFFS);

    logic [31:0] r_dur_mem [MAX_SEGMENTS];
    logic [63:0] r_coef_mem [DEPTH];
    logic [31:0] r_dur_q;
    logic [63:0] r_mem_q;

    logic [AW-1:0] r_clr_addr;
    logic [SW-1:0] r_seg;
    logic [31:0]   r_begin, r_cl, r_t;
    logic [1:0]    r_axis;
    logic [2:0]    r_d, r_j;
    logic [KW-1:0] r_k;
    logic          r_op3, r_neg;
    logic [63:0]   r_tc, r_acc, r_mag, r_plo, r_phi, r_prod;
    logic [63:0]   r_res [AXES];

    logic [8:0]    seg_in_ext, n_cnt;
    logic          coef_ok, dur_ok, coef_we;
    logic [AW-1:0] coef_waddr, coef_raddr;
    logic [32:0]   el, srch_sum;
    logic [31:0]   elc, cl_next;
    logic [4:0]    scl_f;
    logic signed [69:0] sprod;
    logic [63:0]   tc_scaled, prod_next, add_next;
    logic [95:0]   pfull;
    logic [79:0]   rnd;
    logic signed [64:0] ssum;

    assign seg_in_ext = 9'(i_segment_index);
    assign dur_ok  = seg_in_ext < 9'(MAX_SEGMENTS);
    assign coef_ok = dur_ok && (i_axis < 2'(AXES)) && (5'(i_coeff_index) < 5'(NUM_COEFFS));
    assign coef_we = i_cmd.clr_step || (i_cmd.load && i_op == OP_WR_COEF && coef_ok);
    assign coef_waddr = i_cmd.clr_step ? r_clr_addr :
        AW'(32'(i_segment_index) * ROWLEN + 32'(i_axis) * NUM_COEFFS + 32'(i_coeff_index));
    assign coef_raddr = AW'(32'(r_seg) * ROWLEN + 32'(r_axis) * NUM_COEFFS + 32'(r_k));

    always_ff @(posedge i_clk) begin
        if (coef_we) r_coef_mem[coef_waddr] <= i_cmd.clr_step ? 64'd0 : i_coeff_value;
        r_mem_q <= r_coef_mem[coef_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_op == OP_WR_DUR && dur_ok) begin
            r_dur_mem[seg_in_ext[SW-1:0]] <= i_duration_value;
        end
        r_dur_q <= r_dur_mem[r_seg];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // clamp elapsed time (sample) or query time (eval) to [0, trajectory length]
    assign el      = {1'b0, i_query_time} - {1'b0, i_start_time};
    assign elc     = (i_op == OP_SAMPLE) ? (el[32] ? 32'd0 : el[31:0]) : i_query_time;
    assign cl_next = (elc > i_traj_len) ? i_traj_len : elc;

    assign n_cnt    = (9'(i_segment_count) > 9'(MAX_SEGMENTS)) ? 9'(MAX_SEGMENTS)
                                                              : 9'(i_segment_count);
    assign srch_sum = 33'(r_begin) + 33'(r_dur_q);

    // coefficient scaling by one factor of the falling factorial
    assign scl_f     = 5'(r_k) - 5'(r_j);
    assign sprod     = 70'($signed(r_tc)) * 70'($signed({1'b0, scl_f}));
    assign tc_scaled = (sprod > 70'(SAT_MAX)) ? SAT_MAX :
                       (sprod < 70'(SAT_MIN)) ? SAT_MIN : sprod[63:0];

    // |acc| * t, round half away from zero, drop 16 fraction bits, saturate
    assign pfull     = {r_phi, 32'd0} + 96'(r_plo) + 96'h8000;
    assign rnd       = pfull[95:16];
    assign prod_next = (|rnd[79:63]) ? (r_neg ? SAT_MIN : SAT_MAX)
                                     : (r_neg ? (64'd0 - rnd[63:0]) : rnd[63:0]);

    assign ssum     = {r_prod[63], r_prod} + {r_tc[63], r_tc};
    assign add_next = (ssum[64] != ssum[63]) ? (ssum[64] ? SAT_MIN : SAT_MAX) : ssum[63:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seg   <= '0;
            r_begin <= '0;
            r_axis  <= '0;
            r_cl    <= cl_next;
            r_t     <= cl_next;
            r_op3   <= (i_op == OP_SAMPLE);
            r_d     <= (i_op == OP_SAMPLE) ? 3'd0 : i_deriv_order;
        end
        if (i_cmd.s_adv) begin
            r_begin <= srch_sum[31:0];
            r_seg   <= r_seg + SW'(1);
        end
        if (i_cmd.s_fin)    r_t <= r_cl - r_begin;
        if (i_cmd.ax_start) r_k <= KW'(NUM_COEFFS - 1);
        if (i_cmd.k_dec)    r_k <= r_k - KW'(1);
        if (i_cmd.ax_next)  r_axis <= r_axis + 2'd1;
        if (i_cmd.ord_next) begin
            r_d    <= r_d + 3'd1;
            r_axis <= '0;
        end
        if (i_cmd.rw) begin
            r_tc <= r_mem_q;
            r_j  <= '0;
        end
        if (i_cmd.scl) begin
            r_tc <= tc_scaled;
            r_j  <= r_j + 3'd1;
        end
        if (i_cmd.mabs) begin
            r_neg <= r_acc[63];
            r_mag <= r_acc[63] ? (64'd0 - r_acc) : r_acc;
        end
        if (i_cmd.mlo)  r_plo  <= 64'(r_mag[31:0]) * 64'(r_t);
        if (i_cmd.mhi)  r_phi  <= 64'(r_mag[63:32]) * 64'(r_t);
        if (i_cmd.mrnd) r_prod <= prod_next;
        if (i_cmd.add)  r_acc  <= o_stat.k_first ? r_tc : add_next;
        if (i_cmd.ax_zero)  r_res[r_axis] <= 64'd0;
        if (i_cmd.ax_store) r_res[r_axis] <= r_acc;
    end

    always_comb begin
        o_stat.clr_done  = (r_clr_addr == AW'(DEPTH - 1));
        o_stat.n_zero    = (n_cnt == 9'd0);
        o_stat.srch_more = ((9'(r_seg) + 9'd1) < n_cnt) && (srch_sum <= 33'(r_cl));
        o_stat.zero_axis = (n_cnt == 9'd0) || (5'(r_d) >= 5'(NUM_COEFFS));
        o_stat.scl_done  = (r_j == r_d);
        o_stat.k_first   = (r_k == KW'(NUM_COEFFS - 1));
        o_stat.k_done    = (5'(r_k) == 5'(r_d));
        o_stat.ax_last   = (r_axis == 2'(AXES - 1));
        o_stat.ord_last  = r_op3 ? (r_d == SAMPLE_LAST_ORDER) : 1'b1;
    end

    assign o_order   = r_d;
    assign o_x_value = r_res[0];
    assign o_y_value = r_res[1];
    assign o_z_value = r_res[2];

endmodule

// ===== rtl/piecewise_poly_traj_eval_core.sv =====
// After an accept, a segment search steps through the stored durations (skipped when the
// segment count is zero); then per order and axis each coefficient step reads and scales a
// coefficient, multiplies the sum by t and rounds (not for the first), and adds. Each result
// is pushed once the output register is free. One item is taken at a time, only while idle;
// a sample run gives position to jerk. Reset (synchronous, active low) clears control and
// config registers, then a clearing pass zeroes coefficients; no input.
module piecewise_poly_traj_eval_core
    import ppte_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int NUM_COEFFS   = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // segment_index, axis, coeff_index, coeff_value, duration_value, query_time,
    // deriv_order, zero fill
    input  logic [143:0] s_axis_tdata,
    // opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // order_out, x_value, y_value, z_value, zero fill
    output logic [199:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    logic [31:0] r_start_time, r_traj_len;
    logic [4:0]  r_segment_count;
    logic        r_ovalid, r_olast;
    logic [2:0]  r_oorder;
    logic [63:0] r_ox, r_oy, r_oz;

    t_cmd        cmd;
    t_stat       stat;
    t_op         op;
    logic        accept, out_free;
    logic [2:0]  dp_order;
    logic [63:0] dp_x, dp_y, dp_z;

    assign op       = t_op'(s_axis_tuser);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time     <= '0;
            r_traj_len       <= '0;
            r_segment_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_TIME:     r_start_time     <= i_cfg_wdata;
                CFG_TRAJ_LEN:       r_traj_len       <= i_cfg_wdata;
                CFG_SEGMENT_COUNT:  r_segment_count  <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    ppte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (op),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ppte_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .NUM_COEFFS   (NUM_COEFFS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (op),
        .i_segment_index  (s_axis_tdata[3:0]),
        .i_axis           (s_axis_tdata[5:4]),
        .i_coeff_index    (s_axis_tdata[8:6]),
        .i_coeff_value    (s_axis_tdata[72:9]),
        .i_duration_value (s_axis_tdata[104:73]),
        .i_query_time     (s_axis_tdata[136:105]),
        .i_deriv_order    (s_axis_tdata[139:137]),
        .i_start_time     (r_start_time),
        .i_traj_len       (r_traj_len),
        .i_segment_count  (r_segment_count),
        .o_order          (dp_order),
        .o_x_value        (dp_x),
        .o_y_value        (dp_y),
        .o_z_value        (dp_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (cmd.push) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.push) begin
            r_oorder <= dp_order;
            r_ox     <= dp_x;
            r_oy     <= dp_y;
            r_oz     <= dp_z;
            r_olast  <= stat.ord_last;
        end
    end

    assign s_axis_tready = cmd.idle;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {5'd0, r_oz, r_oy, r_ox, r_oorder};

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result pushed over a pending transaction");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(!i_rst_n) && i_rst_n) |-> !s_axis_tready)
        else $error("input taken before coefficient clearing");

    a_high_order_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] > SAMPLE_LAST_ORDER)) |-> m_axis_tlast)
        else $error("single-order result without last");
`endif

endmodule
